@@ src/ppe_pkg.sv @@
// shared types and constants of the particle pool engine
// no dependencies; used by particle_pool_engine_core
`default_nettype none

package ppe_pkg;

  localparam logic [1:0] KIND_EMIT    = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RENDER  = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  typedef enum logic [2:0] {
    REG_VEL_SPREAD_X   = 3'd0,
    REG_VEL_SPREAD_Y   = 3'd1,
    REG_START_SIZE     = 3'd2,
    REG_START_SIZE_SPR = 3'd3,
    REG_FINAL_SIZE     = 3'd4,
    REG_LIFESPAN       = 3'd5,
    REG_START_RGBA     = 3'd6,
    REG_FINAL_RGBA     = 3'd7
  } cfg_reg_t;

  localparam int unsigned NUM_REGS = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMIT_MUL,
    ST_EMIT_WR,
    ST_TICK_RD,
    ST_TICK_MUL,
    ST_TICK_WR,
    ST_REND_RD,
    ST_REND_DIV,
    ST_REND_MUL,
    ST_REND_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        step_time;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic [15:0]        rand_vx;
    logic [15:0]        rand_vy;
    logic [15:0]        rand_size;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         slot;
    logic               alive;
    logic signed [31:0] at_x;
    logic signed [31:0] at_y;
    logic signed [31:0] spin;
    logic [31:0]        quad_size;
    logic [31:0]        quad_rgba;
    logic               last_slot;
  } out_item_t;

  // one pool entry as held in the slot memory
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] spin;
    logic [31:0]        birth_size;
    logic [31:0]        death_size;
    logic [31:0]        life_left;
    logic [31:0]        life_total;
    logic [31:0]        birth_rgba;
    logic [31:0]        death_rgba;
  } slot_word_t;

  localparam int unsigned DIV_STEPS = 17;
  localparam logic [16:0] FRAC_ONE  = 17'd65536;

endpackage

`default_nettype wire

@@ src/particle_pool_engine_core.sv @@
// particle pool engine top level: slot memory, sequencer, divider, apb registers
// depends on ppe_pkg
//
// channel | direction | handshake          | payload
// in_     | in        | in_valid/in_ready  | ppe_pkg::in_item_t (emit, tick, render)
// out_    | out       | out_valid/out_ready| ppe_pkg::out_item_t (one per slot on render)
// cfg     | in/out    | psel/penable/pready| 8 x 32-bit registers at 4*i
//
// emit passes a multiply and a write state; tick reads each slot and, if live, multiplies
// and writes it back; render reads each slot and runs a live one through the
// one-bit-a-cycle restoring divider for the life fraction and a multiply; output waits on any out stall
// a request is taken only between items; the output register lets the next
// request in while the last render result waits
// reset is synchronous, active low, clears the live flags and next slot at once
`default_nettype none

module particle_pool_engine_core #(
  parameter int unsigned POOL_SLOTS = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  ppe_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output ppe_pkg::out_item_t  out_data,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [4:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // configuration registers
  logic [31:0] cfg_r [ppe_pkg::NUM_REGS];
  logic        cfg_we;
  logic [2:0]  cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_sel = paddr[4:2];
  assign prdata  = cfg_r[cfg_sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[ppe_pkg::REG_VEL_SPREAD_X]   <= 32'd0;
      cfg_r[ppe_pkg::REG_VEL_SPREAD_Y]   <= 32'd0;
      cfg_r[ppe_pkg::REG_START_SIZE]     <= 32'd65536;
      cfg_r[ppe_pkg::REG_START_SIZE_SPR] <= 32'd0;
      cfg_r[ppe_pkg::REG_FINAL_SIZE]     <= 32'd0;
      cfg_r[ppe_pkg::REG_LIFESPAN]       <= 32'd65536;
      cfg_r[ppe_pkg::REG_START_RGBA]     <= 32'hffffffff;
      cfg_r[ppe_pkg::REG_FINAL_RGBA]     <= 32'd0;
    end else if (cfg_we) begin
      cfg_r[cfg_sel] <= pwdata;
    end
  end

  // control state
  ppe_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [IDX_W-1:0] next_slot_r, next_slot_nxt;
  logic [POOL_SLOTS-1:0] live_r, live_nxt;
  logic [4:0]  div_cnt_r, div_cnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  // payload
  ppe_pkg::in_item_t  req_r;
  ppe_pkg::out_item_t out_data_r, out_data_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [16:0] quo_r, quo_nxt;

  logic signed [48:0] evx_r, evy_r;
  logic [47:0]        esz_r;
  logic signed [64:0] tpx_r, tpy_r;
  logic signed [50:0] sz_prod_r;
  logic signed [26:0] ch_prod_r [4];

  // slot memory
  ppe_pkg::slot_word_t mem [POOL_SLOTS];
  ppe_pkg::slot_word_t mem_q;
  ppe_pkg::slot_word_t mem_wd;
  logic                mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_r] <= mem_wd;
    end
    mem_q <= mem[slot_r];
  end

  logic in_acc, slot_live, slot_last, out_load;
  assign in_ready  = (state_r == ppe_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_live = live_r[slot_r];
  assign slot_last = (slot_r == LAST_IDX);
  assign out_load  = (state_r == ppe_pkg::ST_REND_OUT) && (!out_valid_r || out_ready);

  // divider step
  logic [32:0] rem_src, rem_diff;
  logic        rem_ge;
  always_comb begin
    rem_src  = (div_cnt_r == 5'd0) ? {1'b0, mem_q.life_left} : rem_r;
    rem_ge   = (rem_src >= {1'b0, mem_q.life_total});
    rem_diff = rem_ge ? (rem_src - {1'b0, mem_q.life_total}) : rem_src;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ppe_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_data.kind)
            ppe_pkg::KIND_EMIT:   state_nxt = ppe_pkg::ST_EMIT_MUL;
            ppe_pkg::KIND_TICK:   state_nxt = ppe_pkg::ST_TICK_RD;
            ppe_pkg::KIND_RENDER: state_nxt = ppe_pkg::ST_REND_RD;
            default:              state_nxt = ppe_pkg::ST_IDLE;
          endcase
        end
      end
      ppe_pkg::ST_EMIT_MUL: state_nxt = ppe_pkg::ST_EMIT_WR;
      ppe_pkg::ST_EMIT_WR:  state_nxt = ppe_pkg::ST_IDLE;
      ppe_pkg::ST_TICK_RD: begin
        if (slot_live) begin
          state_nxt = ppe_pkg::ST_TICK_MUL;
        end else if (slot_last) begin
          state_nxt = ppe_pkg::ST_IDLE;
        end
      end
      ppe_pkg::ST_TICK_MUL: state_nxt = ppe_pkg::ST_TICK_WR;
      ppe_pkg::ST_TICK_WR:  state_nxt = slot_last ? ppe_pkg::ST_IDLE : ppe_pkg::ST_TICK_RD;
      ppe_pkg::ST_REND_RD:  state_nxt = slot_live ? ppe_pkg::ST_REND_DIV : ppe_pkg::ST_REND_OUT;
      ppe_pkg::ST_REND_DIV: begin
        if (div_cnt_r == 5'(ppe_pkg::DIV_STEPS - 1)) begin
          state_nxt = ppe_pkg::ST_REND_MUL;
        end
      end
      ppe_pkg::ST_REND_MUL: state_nxt = ppe_pkg::ST_REND_OUT;
      ppe_pkg::ST_REND_OUT: begin
        if (out_load) begin
          state_nxt = slot_last ? ppe_pkg::ST_IDLE : ppe_pkg::ST_REND_RD;
        end
      end
      default: state_nxt = ppe_pkg::ST_IDLE;
    endcase
  end

  // datapath and control outputs
  logic [16:0]        frac;
  logic [32:0]        size_sum;
  logic signed [50:0] sz_acc;
  logic signed [26:0] ch_acc;
  logic [7:0]         ch_d;
  ppe_pkg::slot_word_t tw;

  always_comb begin
    slot_nxt      = slot_r;
    next_slot_nxt = next_slot_r;
    live_nxt      = live_r;
    div_cnt_nxt   = div_cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    mem_we        = 1'b0;
    mem_wd        = mem_q;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    size_sum      = '0;
    sz_acc        = '0;
    ch_acc        = '0;
    ch_d          = '0;
    tw            = mem_q;

    frac = 17'd0;
    if (mem_q.life_total != 32'd0) begin
      frac = (quo_r > ppe_pkg::FRAC_ONE) ? ppe_pkg::FRAC_ONE : quo_r;
    end

    case (state_r)
      ppe_pkg::ST_IDLE: begin
        if (in_acc) begin
          slot_nxt = (in_data.kind == ppe_pkg::KIND_EMIT) ? next_slot_r : '0;
        end
      end
      ppe_pkg::ST_EMIT_WR: begin
        mem_we            = 1'b1;
        mem_wd.pos_x      = req_r.origin_x;
        mem_wd.pos_y      = req_r.origin_y;
        mem_wd.vel_x      = sat32(64'(req_r.speed_x) + 64'(evx_r >>> 16));
        mem_wd.vel_y      = sat32(64'(req_r.speed_y) + 64'(evy_r >>> 16));
        mem_wd.spin       = '0;
        size_sum          = {1'b0, cfg_r[ppe_pkg::REG_START_SIZE]} + {1'b0, esz_r[47:16]};
        mem_wd.birth_size = size_sum[32] ? 32'hffffffff : size_sum[31:0];
        mem_wd.death_size = cfg_r[ppe_pkg::REG_FINAL_SIZE];
        mem_wd.life_left  = cfg_r[ppe_pkg::REG_LIFESPAN];
        mem_wd.life_total = cfg_r[ppe_pkg::REG_LIFESPAN];
        mem_wd.birth_rgba = cfg_r[ppe_pkg::REG_START_RGBA];
        mem_wd.death_rgba = cfg_r[ppe_pkg::REG_FINAL_RGBA];
        live_nxt[slot_r]  = 1'b1;
        next_slot_nxt     = (slot_r == LAST_IDX) ? '0 : slot_r + 1'b1;
      end
      ppe_pkg::ST_TICK_RD: begin
        if (!slot_live && !slot_last) begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      ppe_pkg::ST_TICK_WR: begin
        mem_we = 1'b1;
        if (req_r.step_time >= mem_q.life_left) begin
          tw.life_left     = '0;
          live_nxt[slot_r] = 1'b0;
        end else begin
          tw.life_left = mem_q.life_left - req_r.step_time;
          tw.pos_x     = sat32(64'(mem_q.pos_x) + 64'(tpx_r >>> 16));
          tw.pos_y     = sat32(64'(mem_q.pos_y) + 64'(tpy_r >>> 16));
          // 10 * dt as 8 * dt + 2 * dt
          tw.spin      = sat32(64'(mem_q.spin) + $signed({28'd0,
                           ({4'd0, req_r.step_time} << 3) + ({4'd0, req_r.step_time} << 1)}));
        end
        mem_wd = tw;
        if (!slot_last) begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      ppe_pkg::ST_REND_RD: begin
        div_cnt_nxt = '0;
        quo_nxt     = '0;
      end
      ppe_pkg::ST_REND_DIV: begin
        quo_nxt     = {quo_r[15:0], rem_ge};
        rem_nxt     = {rem_diff[31:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 5'd1;
      end
      ppe_pkg::ST_REND_OUT: begin
        if (out_load) begin
          out_data_nxt           = '0;
          out_data_nxt.slot      = 6'(slot_r);
          out_data_nxt.last_slot = slot_last;
          if (slot_live) begin
            out_data_nxt.alive     = 1'b1;
            out_data_nxt.at_x      = mem_q.pos_x;
            out_data_nxt.at_y      = mem_q.pos_y;
            out_data_nxt.spin      = mem_q.spin;
            sz_acc = $signed({3'd0, mem_q.death_size, 16'd0}) + sz_prod_r;
            out_data_nxt.quad_size = sz_acc[47:16];
            for (int c = 0; c < 4; c++) begin
              ch_d   = mem_q.death_rgba[c*8 +: 8];
              ch_acc = $signed({3'd0, ch_d, 16'd0}) + ch_prod_r[c];
              out_data_nxt.quad_rgba[c*8 +: 8] = ch_acc[23:16];
            end
          end
          if (!slot_last) begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppe_pkg::ST_IDLE;
      slot_r      <= '0;
      next_slot_r <= '0;
      live_r      <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      next_slot_r <= next_slot_nxt;
      live_r      <= live_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers and multipliers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_data;
    end
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    out_data_r <= out_data_nxt;
    if (state_r == ppe_pkg::ST_EMIT_MUL) begin
      evx_r <= $signed({1'b0, req_r.rand_vx}) * $signed(cfg_r[ppe_pkg::REG_VEL_SPREAD_X]);
      evy_r <= $signed({1'b0, req_r.rand_vy}) * $signed(cfg_r[ppe_pkg::REG_VEL_SPREAD_Y]);
      esz_r <= req_r.rand_size * cfg_r[ppe_pkg::REG_START_SIZE_SPR];
    end
    if (state_r == ppe_pkg::ST_TICK_MUL) begin
      tpx_r <= mem_q.vel_x * $signed({1'b0, req_r.step_time});
      tpy_r <= mem_q.vel_y * $signed({1'b0, req_r.step_time});
    end
    if (state_r == ppe_pkg::ST_REND_MUL) begin
      // blend as death + (birth - death) * p
      sz_prod_r <= ($signed({1'b0, mem_q.birth_size}) - $signed({1'b0, mem_q.death_size}))
                   * $signed({1'b0, frac});
      for (int c = 0; c < 4; c++) begin
        ch_prod_r[c] <= ($signed({1'b0, mem_q.birth_rgba[c*8 +: 8]})
                         - $signed({1'b0, mem_q.death_rgba[c*8 +: 8]}))
                        * $signed({1'b0, frac});
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_tick_wr_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppe_pkg::ST_TICK_WR) |-> live_r[slot_r])
    else $error("tick write-back on a slot that is not live");

  a_no_write_in_render: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppe_pkg::ST_REND_RD || state_r == ppe_pkg::ST_REND_DIV ||
     state_r == ppe_pkg::ST_REND_MUL || state_r == ppe_pkg::ST_REND_OUT) |-> !mem_we)
    else $error("slot memory written during render");

  // a zero total life leaves the quotient unused
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppe_pkg::ST_REND_DIV && div_cnt_r != 5'd0 && mem_q.life_total != 32'd0)
      |-> (rem_r[32:1] < mem_q.life_total))
    else $error("divider remainder not below divisor");

  a_next_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppe_pkg::ST_EMIT_WR) |=> (next_slot_r <= LAST_IDX))
    else $error("next slot outside the pool");

endmodule

`default_nettype wire
